// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; empty when synthesised.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PSC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/psc_pkg.sv =====
`default_nettype none
package psc_pkg;

   localparam int SampleW = 16;
   localparam int DiffW   = SampleW + 1;
   localparam int ProdW   = 2 * DiffW;
   localparam int FracW   = 8;
   localparam int TermW   = ProdW - FracW;
   localparam int SumW    = TermW + 2;
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      REG_KP      = 3'd0,
      REG_KI      = 3'd1,
      REG_KD      = 3'd2,
      REG_OUT_MIN = 3'd3,
      REG_OUT_MAX = 3'd4,
      REG_REVERSE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SampleW-1:0] kp_gain;
      logic signed [SampleW-1:0] ki_gain;
      logic signed [SampleW-1:0] kd_gain;
      logic signed [SampleW-1:0] out_min;
      logic signed [SampleW-1:0] out_max;
      logic                      reverse_direction;
      logic                      limit_update;
   } cfg_type;

   typedef struct packed {
      logic signed [DiffW-1:0] err;
      logic signed [DiffW-1:0] dmeas;
   } diff_type;

   typedef struct packed {
      logic signed [TermW-1:0] pterm;
      logic signed [TermW-1:0] iterm;
      logic signed [TermW-1:0] dterm;
   } term_type;

   // Above hi gives hi, otherwise below lo gives lo.
   function automatic logic signed [SampleW-1:0] clamp_limits(
      input logic signed [SumW-1:0]    v,
      input logic signed [SampleW-1:0] lo,
      input logic signed [SampleW-1:0] hi
   );
      logic signed [SampleW-1:0] res;
      if (v > SumW'(hi)) begin
         res = hi;
      end else if (v < SumW'(lo)) begin
         res = lo;
      end else begin
         res = SampleW'(v);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/psc_csr.sv =====
`default_nettype none
module psc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [psc_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [psc_pkg::SampleW-1:0]   csr_wdata,
   output psc_pkg::cfg_type                   cfg
);
   import psc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      cfg_in.limit_update = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_KP:      cfg_in.kp_gain = csr_wdata;
            REG_KI:      cfg_in.ki_gain = csr_wdata;
            REG_KD:      cfg_in.kd_gain = csr_wdata;
            REG_OUT_MIN: cfg_in.out_min = csr_wdata;
            REG_OUT_MAX: cfg_in.out_max = csr_wdata;
            REG_REVERSE: cfg_in.reverse_direction = csr_wdata[0];
            default: ;
         endcase
         // flag the integral for re-clamping on the next cycle
         cfg_in.limit_update = csr_index inside {REG_OUT_MIN, REG_OUT_MAX};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain           <= '0;
         cfg_ff.ki_gain           <= '0;
         cfg_ff.kd_gain           <= '0;
         cfg_ff.out_min           <= {1'b1, {(SampleW-1){1'b0}}};
         cfg_ff.out_max           <= {1'b0, {(SampleW-1){1'b1}}};
         cfg_ff.reverse_direction <= 1'b0;
         cfg_ff.limit_update      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/psc_input.sv =====
`default_nettype none
`include "assert_macros.svh"
module psc_input (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire logic signed [psc_pkg::SampleW-1:0] setpoint,
   input  wire logic signed [psc_pkg::SampleW-1:0] measurement,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      psc_pkg::diff_type             out_data
);
   import psc_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SampleW-1:0] prev_ff, prev_in;
   diff_type                  data_ff, data_in;
   logic                      take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      prev_in  = take ? measurement : prev_ff;
      data_in  = data_ff;
      if (take) begin
         data_in.err   = DiffW'(setpoint) - DiffW'(measurement);
         data_in.dmeas = DiffW'(measurement) - DiffW'(prev_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `PSC_ASSERT_NEXT(a_prev_follows, clock, reset, take, prev_ff == $past(measurement))

endmodule
`default_nettype wire

// ===== hw/rtl/psc_product.sv =====
`default_nettype none
module psc_product (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire psc_pkg::cfg_type      cfg,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire psc_pkg::diff_type     in_data,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      psc_pkg::term_type     out_data
);
   import psc_pkg::*;

   logic                    valid_ff, valid_in;
   term_type                data_ff, data_in;
   logic signed [DiffW-1:0] kp_eff, ki_eff, kd_eff;
   logic signed [ProdW-1:0] p_full, i_full, d_full;
   logic                    take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // reverse acting: negate all gains; -32768 becomes +32768 in 17 bits
   always_comb begin
      kp_eff = cfg.reverse_direction ? -DiffW'(cfg.kp_gain) : DiffW'(cfg.kp_gain);
      ki_eff = cfg.reverse_direction ? -DiffW'(cfg.ki_gain) : DiffW'(cfg.ki_gain);
      kd_eff = cfg.reverse_direction ? -DiffW'(cfg.kd_gain) : DiffW'(cfg.kd_gain);
      p_full = ProdW'(kp_eff) * ProdW'(in_data.err);
      i_full = ProdW'(ki_eff) * ProdW'(in_data.err);
      d_full = ProdW'(kd_eff) * ProdW'(in_data.dmeas);
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      data_in  = data_ff;
      if (take) begin
         // drop the fraction bits: arithmetic shift, rounds to minus infinity
         data_in.pterm = p_full[ProdW-1:FracW];
         data_in.iterm = i_full[ProdW-1:FracW];
         data_in.dterm = d_full[ProdW-1:FracW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/psc_output.sv =====
`default_nettype none
`include "assert_macros.svh"
module psc_output (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psc_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire psc_pkg::term_type             in_data,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic signed [psc_pkg::SampleW-1:0] drive
);
   import psc_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SampleW-1:0] integral_ff, integral_in;
   logic signed [SampleW-1:0] drive_ff, drive_in;
   logic signed [SampleW-1:0] integral_next;
   logic signed [SumW-1:0]    integral_sum, drive_sum;
   logic                      take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      integral_sum  = SumW'(integral_ff) + SumW'(in_data.iterm);
      integral_next = clamp_limits(integral_sum, cfg.out_min, cfg.out_max);
      drive_sum     = SumW'(in_data.pterm) + SumW'(integral_next) - SumW'(in_data.dterm);
      valid_in      = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      drive_in      = take ? clamp_limits(drive_sum, cfg.out_min, cfg.out_max) : drive_ff;
      integral_in   = integral_ff;
      if (cfg.limit_update) begin
         integral_in = clamp_limits(SumW'(integral_ff), cfg.out_min, cfg.out_max);
      end else if (take) begin
         integral_in = integral_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         integral_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         integral_ff <= integral_in;
      end
      drive_ff <= drive_in;
   end

   assign out_valid = valid_ff;
   assign drive     = drive_ff;

   `PSC_ASSERT_IMPLY(a_drive_in_limits, clock, reset,
      valid_ff && (cfg.out_min <= cfg.out_max),
      (drive_ff >= cfg.out_min) && (drive_ff <= cfg.out_max))
   `PSC_ASSERT_NEXT(a_integral_holds, clock, reset,
      !take && !cfg.limit_update && !reset, $stable(integral_ff))

endmodule
`default_nettype wire

// ===== hw/rtl/pid_step_clamped.sv =====
// pid_step_clamped: fixed-point PID controller, derivative on the measurement.
// Input channel (req_): one transaction is one sample, setpoint and measurement.
// Result channel (rsp_): one transaction per sample, the clamped drive value.
// Configuration (csr_): write gains, limits and direction while the block is
// idle; a limit write sets a registered flag that re-clamps the stored integral.
// Pipeline: an accepted sample passes the difference, product and result
// registers in turn; one sample per cycle while rsp_tready is high, products
// registered ahead. The integral add and clamp in the result stage and the
// previous measurement in the difference stage close the sample-to-sample loops.
// Stall: when rsp_tready is low the result register holds and each earlier
// stage fills in turn; req_tready drops only once all three stages are full.
// Reset: synchronous, active high; clears the valid bits, integral and previous
// measurement, and restores gains 0, limits -32768..32767, forward direction.
`default_nettype none
module pid_step_clamped (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] setpoint, [31:16] measurement
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [15:0] drive
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import psc_pkg::*;

   cfg_type                   cfg;
   diff_type                  diff_data;
   term_type                  term_data;
   logic                      diff_valid, diff_ready;
   logic                      term_valid, term_ready;
   logic signed [SampleW-1:0] setpoint, measurement, drive;

   // unpack the sample transaction
   assign setpoint    = req_tdata[SampleW-1:0];
   assign measurement = req_tdata[2*SampleW-1:SampleW];

   psc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // form error and measurement change, advance previous measurement
   psc_input u_input (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .setpoint    (setpoint),
      .measurement (measurement),
      .out_valid   (diff_valid),
      .out_ready   (diff_ready),
      .out_data    (diff_data)
   );

   // three gain products, scaled down by the fraction bits
   psc_product u_product (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_data)
   );

   // integral update, sum and clamp into the result register
   psc_output u_output (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .drive     (drive)
   );

   assign rsp_tdata = drive;

endmodule
`default_nettype wire
